// File: hdl/fcpc_pkg.sv
// ----------------------------------------------------------------------------
// Flash charger PWM controller package
// Shared sizes, register codes, band tables and the control program ROM.
// ----------------------------------------------------------------------------
package fcpc_pkg;

	localparam int AVG_DEPTH = 5;

	localparam int SAMPLE_W = 10;
	localparam int PTR_W    = $clog2(AVG_DEPTH);
	localparam int FILL_W   = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W    = SAMPLE_W + $clog2(AVG_DEPTH);

	// Reciprocals are scaled by 2^RECIP_SHIFT. With 2^RECIP_SHIFT >= 1024 * n * n
	// for every divisor n up to sixteen, floor(sum * m >> RECIP_SHIFT) is exact.
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int RECIP_IDX_W = 5;
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam int THR_W   = 10;
	localparam int HYST_W  = 8;
	localparam int LIMIT_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [THR_W-1:0]   THR_RESET   = 10'd420;
	localparam logic [HYST_W-1:0]  HYST_RESET  = 8'd70;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_READY_THRESHOLD   = 2'd0,
		REG_HYSTERESIS_OFFSET = 2'd1,
		REG_START_COUNT_LIMIT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_STOP   = 2'd1,
		ACT_CHANGE = 2'd2,
		ACT_START  = 2'd3
	} pwm_act_t;

	// Voltage bands: lower bound inclusive, upper bound exclusive.
	localparam logic signed [10:0] BAND_LO [4] = '{-11'sd200, 11'sd100, 11'sd200, 11'sd250};
	localparam logic signed [10:0] BAND_HI [4] = '{11'sd100, 11'sd200, 11'sd250, 11'sd330};
	localparam logic [7:0] BAND_T_HIGH [4] = '{8'd90, 8'd90, 8'd38, 8'd38};
	localparam logic [8:0] BAND_T_LOW  [4] = '{9'd275, 9'd125, 9'd24, 9'd12};

	// Band number 1 to 4, or 0 when the value lies in no band.
	function automatic logic [2:0] find_band(input logic signed [10:0] v);
		logic [2:0] b;
		b = 3'd0;
		for (int k = 0; k < 4; k++) begin
			if (b == 3'd0 && v >= BAND_LO[k] && v < BAND_HI[k]) begin
				b = 3'(k + 1);
			end
		end
		return b;
	endfunction

	// ceil(2^RECIP_SHIFT / n) for the sample counts that can occur.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [RECIP_IDX_W-1:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			5'd1:    m = 19'd262144;
			5'd2:    m = 19'd131072;
			5'd3:    m = 19'd87382;
			5'd4:    m = 19'd65536;
			5'd5:    m = 19'd52429;
			5'd6:    m = 19'd43691;
			5'd7:    m = 19'd37450;
			5'd8:    m = 19'd32768;
			5'd9:    m = 19'd29128;
			5'd10:   m = 19'd26215;
			5'd11:   m = 19'd23832;
			5'd12:   m = 19'd21846;
			5'd13:   m = 19'd20165;
			5'd14:   m = 19'd18725;
			5'd15:   m = 19'd17477;
			5'd16:   m = 19'd16384;
			default: m = '0;
		endcase
		return m;
	endfunction

	// Control program.
	typedef enum logic [2:0] {
		STEP_WAIT   = 3'd0,
		STEP_RING   = 3'd1,
		STEP_MUL    = 3'd2,
		STEP_AVG    = 3'd3,
		STEP_DECIDE = 3'd4,
		STEP_EMIT   = 3'd5
	} step_t;

	typedef enum logic [1:0] {
		COND_NONE     = 2'd0,
		COND_NO_INPUT = 2'd1,
		COND_OUT_BUSY = 2'd2
	} jump_cond_t;

	typedef struct packed {
		logic       take_input;
		logic       ring_update;
		logic       mul_load;
		logic       avg_load;
		logic       decide;
		logic       emit;
		jump_cond_t cond;
		step_t      jump_step;
		step_t      next_step;
	} ctl_word_t;

	function automatic ctl_word_t ucode_word(input step_t step);
		ctl_word_t w;
		w = '{take_input: 1'b0, ring_update: 1'b0, mul_load: 1'b0, avg_load: 1'b0,
			decide: 1'b0, emit: 1'b0, cond: COND_NONE, jump_step: STEP_WAIT,
			next_step: STEP_WAIT};
		case (step)
			STEP_WAIT: begin
				w.take_input = 1'b1;
				w.cond       = COND_NO_INPUT;
				w.jump_step  = STEP_WAIT;
				w.next_step  = STEP_RING;
			end
			STEP_RING: begin
				w.ring_update = 1'b1;
				w.next_step   = STEP_MUL;
			end
			STEP_MUL: begin
				w.mul_load  = 1'b1;
				w.next_step = STEP_AVG;
			end
			STEP_AVG: begin
				w.avg_load  = 1'b1;
				w.next_step = STEP_DECIDE;
			end
			STEP_DECIDE: begin
				w.decide    = 1'b1;
				w.next_step = STEP_EMIT;
			end
			STEP_EMIT: begin
				w.emit      = 1'b1;
				w.cond      = COND_OUT_BUSY;
				w.jump_step = STEP_EMIT;
				w.next_step = STEP_WAIT;
			end
			default: begin
				w.next_step = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

// File: hdl/flash_charger_pwm_controller.sv
// ----------------------------------------------------------------------------
// Flash charger PWM controller
// Moving average of capacitor voltage samples, flash-ready detection and
// charger PWM band control, run by a small microprogram.
// ----------------------------------------------------------------------------
// A result passes through the sample, sum, product, average, decision and
// output registers in turn after its sample transfer. The six-word control
// program walks ring update, reciprocal multiply, average, decision and output
// load, and takes no new sample until it is back in its wait step; a stalled
// output holds the program in its last step until the output register is free.
// Reset clears the sample ring, pointers, flags and counters at once and loads
// the register defaults (threshold 420, hysteresis 70, start limit 3).
module flash_charger_pwm_controller
	import fcpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Sample channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   sample_value,
	// Result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [9:0]            average_value,
	output logic                  flash_ready,
	output logic                  pwm_running,
	output logic [1:0]            pwm_action,
	output logic [7:0]            pwm_high_time,
	output logic [8:0]            pwm_low_time,
	output logic [2:0]            band_level,
	// Configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [THR_W-1:0]   thr_q;
	logic [HYST_W-1:0]  hyst_q;
	logic [LIMIT_W-1:0] limit_q;

	// Sequencer.
	step_t     step_q;
	ctl_word_t cw;
	logic      jump_taken;
	logic      in_xfer;
	logic      out_busy;

	// Datapath.
	logic [SAMPLE_W-1:0] ring_q [AVG_DEPTH];
	logic [PTR_W-1:0]    ptr_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PROD_W-1:0]   prod_q;
	logic [9:0]          avg_q;
	logic [2:0]          band_q;

	// Controller state.
	logic         ready_q;
	logic         pwm_on_q;
	logic [2:0]   level_q;
	logic [3:0]   start_cnt_q;
	pwm_act_t     action_q;

	// Output register.
	logic         out_valid_q;

	logic signed [10:0] band_in;
	logic [1:0]         level_idx;

	// The control word for the current step comes straight from the ROM.
	assign cw       = ucode_word(step_q);
	assign in_ready = cw.take_input;
	assign in_xfer  = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;

	always_comb begin
		case (cw.cond)
			COND_NO_INPUT: jump_taken = !in_valid;
			COND_OUT_BUSY: jump_taken = out_busy;
			default:       jump_taken = 1'b0;
		endcase
	end

	// While the PWM runs, the band test looks at the sample less the hysteresis.
	always_comb begin
		if (pwm_on_q) begin
			band_in = $signed({1'b0, sample_q}) - $signed({3'b000, hyst_q});
		end else begin
			band_in = $signed({1'b0, sample_q});
		end
	end

	assign level_idx = 2'(level_q - 3'd1);

	// Configuration writes are always accepted; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			hyst_q  <= HYST_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_READY_THRESHOLD:   thr_q   <= cfg_data[THR_W-1:0];
				REG_HYSTERESIS_OFFSET: hyst_q  <= cfg_data[HYST_W-1:0];
				REG_START_COUNT_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Step counter: follow the control word's jump when its condition holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (jump_taken) begin
			step_q <= cw.jump_step;
		end else begin
			step_q <= cw.next_step;
		end
	end

	// Sample ring and running sum. The sum drops the slot being overwritten and
	// adds the new sample, so unwritten slots count as zero during warm-up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AVG_DEPTH; k++) begin
				ring_q[k] <= '0;
			end
			ptr_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cw.ring_update) begin
			ring_q[ptr_q] <= sample_q;
			sum_q <= sum_q - SUM_W'(ring_q[ptr_q]) + SUM_W'(sample_q);
			if (ptr_q == PTR_W'(AVG_DEPTH - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			if (fill_q != FILL_W'(AVG_DEPTH)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= sample_value;
		end
		if (cw.mul_load) begin
			// Division by the sample count as a multiply by its reciprocal.
			prod_q <= PROD_W'(sum_q) * PROD_W'(recip_of(RECIP_IDX_W'(fill_q)));
		end
		if (cw.avg_load) begin
			avg_q  <= prod_q[RECIP_SHIFT +: 10];
			band_q <= find_band(band_in);
		end
	end

	// Charge decision: ready detection first, then band tracking or start-up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q     <= 1'b0;
			pwm_on_q    <= 1'b0;
			level_q     <= 3'd0;
			start_cnt_q <= 4'd0;
			action_q    <= ACT_NONE;
		end else if (cw.decide) begin
			action_q <= ACT_NONE;
			if (avg_q >= thr_q) begin
				ready_q <= 1'b1;
				if (pwm_on_q) begin
					pwm_on_q    <= 1'b0;
					level_q     <= 3'd0;
					start_cnt_q <= 4'd0;
					action_q    <= ACT_STOP;
				end
			end else if (pwm_on_q) begin
				if (band_q != 3'd0 && band_q != level_q) begin
					level_q  <= band_q;
					action_q <= ACT_CHANGE;
				end
			end else if (band_q != 3'd0) begin
				if (start_cnt_q >= limit_q) begin
					pwm_on_q    <= 1'b1;
					level_q     <= band_q;
					ready_q     <= 1'b0;
					start_cnt_q <= 4'd0;
					action_q    <= ACT_START;
				end else begin
					start_cnt_q <= start_cnt_q + 4'd1;
				end
			end
		end
	end

	// Output register: a result waits here while the next sample is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cw.emit && !out_busy) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cw.emit && !out_busy) begin
			average_value <= avg_q;
			flash_ready   <= ready_q;
			pwm_running   <= pwm_on_q;
			pwm_action    <= action_q;
			band_level    <= level_q;
			if (level_q != 3'd0) begin
				pwm_high_time <= BAND_T_HIGH[level_idx];
				pwm_low_time  <= BAND_T_LOW[level_idx];
			end else begin
				pwm_high_time <= '0;
				pwm_low_time  <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A sample transfer always starts the program, so no second one follows.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("sample transfer accepted back to back");

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(AVG_DEPTH) && ptr_q <= PTR_W'(AVG_DEPTH - 1))
		else $error("ring pointer or fill count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pwm_running == (band_level != 3'd0)))
		else $error("band level disagrees with PWM state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pwm_action == ACT_START) |-> (pwm_running && !flash_ready))
		else $error("PWM start reported without running PWM");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pwm_action == ACT_STOP) |-> (!pwm_running && flash_ready))
		else $error("PWM stop reported without ready flag");

endmodule
